FILE: rtl/qrs_pkg.sv
`timescale 1ns / 1ps

package qrs_pkg;

    // number format
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int TOL_W      = 16;

    // divider widths: |c| << FRAC_BITS over |2*c| or |c|
    localparam int NUM_W = DATA_WIDTH + FRAC_BITS;
    localparam int DEN_W = DATA_WIDTH + 1;
    localparam int QUO_W = NUM_W + 1;

    // square root widths
    localparam int RAD_W    = 2 * DATA_WIDTH;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int SQ_REM_W = ROOT_W + 3;

    // discriminant and final sum widths
    localparam int PP_W  = 2 * DATA_WIDTH - FRAC_BITS;
    localparam int DIS_W = PP_W + 2;
    localparam int SUM_W = DATA_WIDTH + 2;

    localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

    // root count codes
    localparam logic [1:0] CNT_NONE   = 2'd0;
    localparam logic [1:0] CNT_LINEAR = 2'd1;
    localparam logic [1:0] CNT_QUAD   = 2'd2;

    // side data that rides along the dividers
    typedef struct packed {
        logic v;
        logic quad;
        logic err;
    } t_div_side;

    // side data that rides along the square root
    typedef struct packed {
        logic                         v;
        logic                         quad;
        logic                         err;
        logic                         real_roots;
        logic                         dneg;
        logic signed [DATA_WIDTH-1:0] p;
        logic signed [DATA_WIDTH-1:0] lin;
    } t_sq_side;

    // clamp a quotient to the data range
    function automatic logic signed [DATA_WIDTH-1:0] sat_quo(input logic signed [QUO_W-1:0] v);
        logic signed [QUO_W-1:0] hi;
        logic signed [QUO_W-1:0] lo;
        hi = QUO_W'(DATA_MAX);
        lo = QUO_W'(DATA_MIN);
        if (v > hi) begin
            return DATA_MAX;
        end else if (v < lo) begin
            return DATA_MIN;
        end
        return v[DATA_WIDTH-1:0];
    endfunction

    // clamp a root sum to the data range
    function automatic logic signed [DATA_WIDTH-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        hi = SUM_W'(DATA_MAX);
        lo = SUM_W'(DATA_MIN);
        if (v > hi) begin
            return DATA_MAX;
        end else if (v < lo) begin
            return DATA_MIN;
        end
        return v[DATA_WIDTH-1:0];
    endfunction

endpackage

FILE: rtl/qrs_div.sv
`timescale 1ns / 1ps

// restoring divider, one quotient bit per stage, sign applied at the end
module qrs_div (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [qrs_pkg::NUM_W-1:0]        i_num,
    input  logic [qrs_pkg::DEN_W-1:0]        i_den,
    input  logic                             i_neg,
    output logic signed [qrs_pkg::QUO_W-1:0] o_quo
);
    import qrs_pkg::*;

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_nq  [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic             r_neg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [DEN_W-1:0] w_rem;
        logic [NUM_W-1:0] w_nq;
        logic [DEN_W-1:0] w_den;
        logic             w_neg;
        logic [DEN_W:0]   w_trial;
        logic             w_take;
        logic [DEN_W-1:0] n_rem;
        logic [NUM_W-1:0] n_nq;

        if (k == 0) begin : g_first
            assign w_rem = '0;
            assign w_nq  = i_num;
            assign w_den = i_den;
            assign w_neg = i_neg;
        end else begin : g_next
            assign w_rem = r_rem[k-1];
            assign w_nq  = r_nq[k-1];
            assign w_den = r_den[k-1];
            assign w_neg = r_neg[k-1];
        end

        // shift in the next dividend bit and try the subtract
        assign w_trial = {w_rem, w_nq[NUM_W-1]};
        assign w_take  = w_trial >= {1'b0, w_den};
        assign n_rem   = w_take ? DEN_W'(w_trial - {1'b0, w_den}) : w_trial[DEN_W-1:0];
        assign n_nq    = {w_nq[NUM_W-2:0], w_take};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_nq[k]  <= n_nq;
                r_den[k] <= w_den;
                r_neg[k] <= w_neg;
            end
        end
    end

    // apply the sign, truncation toward zero
    assign o_quo = r_neg[NUM_W-1] ? -$signed({1'b0, r_nq[NUM_W-1]})
                                  :  $signed({1'b0, r_nq[NUM_W-1]});

endmodule

FILE: rtl/qrs_isqrt.sv
`timescale 1ns / 1ps

// floor square root, one result bit per stage
module qrs_isqrt (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [qrs_pkg::RAD_W-1:0]  i_rad,
    output logic [qrs_pkg::ROOT_W-1:0] o_root
);
    import qrs_pkg::*;

    logic [SQ_REM_W-1:0] r_rem  [ROOT_W];
    logic [ROOT_W-1:0]   r_root [ROOT_W];
    logic [RAD_W-1:0]    r_x    [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [SQ_REM_W-1:0] w_rem;
        logic [ROOT_W-1:0]   w_root;
        logic [RAD_W-1:0]    w_x;
        logic [SQ_REM_W+1:0] w_cur;
        logic [SQ_REM_W+1:0] w_trial;
        logic                w_take;

        if (k == 0) begin : g_first
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_x    = i_rad;
        end else begin : g_next
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_x    = r_x[k-1];
        end

        // bring down two bits, test (4*root + 1)
        assign w_cur   = {w_rem, w_x[RAD_W-1 -: 2]};
        assign w_trial = (SQ_REM_W+2)'({w_root, 2'b01});
        assign w_take  = w_cur >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_take ? SQ_REM_W'(w_cur - w_trial) : w_cur[SQ_REM_W-1:0];
                r_root[k] <= {w_root[ROOT_W-2:0], w_take};
                r_x[k]    <= {w_x[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];

endmodule

FILE: rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps

// channel   | valid    | ready    | payload
// ----------+----------+----------+-------------------------------------------
// coef in   | i_valid  | o_ready  | i_coef_c0, i_coef_c1, i_coef_c2
// roots out | o_valid  | i_ready  | o_root_a/b_real/imag, o_root_count,
//           |          |          | o_divide_error
// config    | i_cfg_we | -        | i_cfg_data (zero tolerance)
//
// one equation per cycle while the output is not stalled; from input beat
// to output beat: input register, 48 divider stages, 3 stages for p*p and
// d, 32 square root stages and the output register. latency is set by the
// divider and square root depths.
// reset clears the valid bits and loads the tolerance with 1.
// a stalled output freezes the whole pipe; the input register still fills
// while it is empty.
module quadratic_root_solver (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [qrs_pkg::TOL_W-1:0]            i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [qrs_pkg::DATA_WIDTH-1:0] i_coef_c0,
    input  logic signed [qrs_pkg::DATA_WIDTH-1:0] i_coef_c1,
    input  logic signed [qrs_pkg::DATA_WIDTH-1:0] i_coef_c2,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [qrs_pkg::DATA_WIDTH-1:0] o_root_a_real,
    output logic signed [qrs_pkg::DATA_WIDTH-1:0] o_root_a_imag,
    output logic signed [qrs_pkg::DATA_WIDTH-1:0] o_root_b_real,
    output logic signed [qrs_pkg::DATA_WIDTH-1:0] o_root_b_imag,
    output logic [1:0]                           o_root_count,
    output logic                                 o_divide_error
);
    import qrs_pkg::*;

    logic                         en;
    logic                         ld_in;
    logic [TOL_W-1:0]             r_tol;

    // input stage
    logic                         r_in_v;
    logic signed [DATA_WIDTH-1:0] r_c0;
    logic signed [DATA_WIDTH-1:0] r_c1;
    logic signed [DATA_WIDTH-1:0] r_c2;

    logic [DATA_WIDTH-1:0]        mag_c0;
    logic [DATA_WIDTH-1:0]        mag_c1;
    logic [DATA_WIDTH-1:0]        mag_c2;
    logic                         in_quad;
    logic                         in_err;
    logic [DEN_W-1:0]             q_den;
    logic                         q_neg;

    logic signed [QUO_W-1:0]      p_quo;
    logic signed [QUO_W-1:0]      q_quo;
    t_div_side                    r_dside [NUM_W];

    // post divider stages
    t_sq_side                     r_m1;
    logic signed [DATA_WIDTH-1:0] r_m1_q;
    t_sq_side                     r_m2;
    logic signed [DATA_WIDTH-1:0] r_m2_q;
    logic [PP_W-1:0]              r_m2_pp;
    logic signed [2*DATA_WIDTH-1:0] pp_full;
    logic signed [DIS_W-1:0]      dis;
    logic signed [DIS_W-1:0]      neg_tol;
    logic [DIS_W-1:0]             dis_mag;
    t_sq_side                     r_m3;
    logic [RAD_W-1:0]             r_m3_rad;

    logic [ROOT_W-1:0]            sq_root;
    t_sq_side                     r_sside [ROOT_W];
    t_sq_side                     fin;

    logic signed [SUM_W-1:0]      neg_p;
    logic signed [SUM_W-1:0]      s_eff;
    logic signed [SUM_W-1:0]      s_full;

    logic                         r_out_v;

    // pipe moves when the output register is free or being drained
    assign en      = !r_out_v || i_ready;
    assign ld_in   = en || !r_in_v;
    assign o_ready = ld_in;

    // tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            r_tol <= i_cfg_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (ld_in) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_in && i_valid) begin
            r_c0 <= i_coef_c0;
            r_c1 <= i_coef_c1;
            r_c2 <= i_coef_c2;
        end
    end

    // magnitudes and case selection
    assign mag_c0  = r_c0[DATA_WIDTH-1] ? DATA_WIDTH'(-r_c0) : DATA_WIDTH'(r_c0);
    assign mag_c1  = r_c1[DATA_WIDTH-1] ? DATA_WIDTH'(-r_c1) : DATA_WIDTH'(r_c1);
    assign mag_c2  = r_c2[DATA_WIDTH-1] ? DATA_WIDTH'(-r_c2) : DATA_WIDTH'(r_c2);
    assign in_quad = mag_c2 > DATA_WIDTH'(r_tol);
    assign in_err  = !in_quad && (r_c1 == '0);
    assign q_den   = {1'b0, in_quad ? mag_c2 : mag_c1};
    assign q_neg   = r_c0[DATA_WIDTH-1] ^ (in_quad ? r_c2[DATA_WIDTH-1] : r_c1[DATA_WIDTH-1]);

    // p = c1 / (2 c2)
    qrs_div u_div_p (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({mag_c1, FRAC_BITS'(0)}),
        .i_den ({mag_c2, 1'b0}),
        .i_neg (r_c1[DATA_WIDTH-1] ^ r_c2[DATA_WIDTH-1]),
        .o_quo (p_quo)
    );

    // q = c0 / c2, or c0 / c1 for the linear root
    qrs_div u_div_q (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({mag_c0, FRAC_BITS'(0)}),
        .i_den (q_den),
        .i_neg (q_neg),
        .o_quo (q_quo)
    );

    // side data along the dividers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_dside[k] <= '0;
            end
        end else if (en) begin
            r_dside[0] <= '{v: r_in_v, quad: in_quad, err: in_err};
            for (int k = 1; k < NUM_W; k++) begin
                r_dside[k] <= r_dside[k-1];
            end
        end
    end

    // clamp the quotients
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1 <= '0;
        end else if (en) begin
            r_m1.v          <= r_dside[NUM_W-1].v;
            r_m1.quad       <= r_dside[NUM_W-1].quad;
            r_m1.err        <= r_dside[NUM_W-1].err;
            r_m1.real_roots <= 1'b0;
            r_m1.dneg       <= 1'b0;
            r_m1.p          <= sat_quo(p_quo);
            r_m1.lin        <= sat_quo(-q_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_q <= sat_quo(q_quo);
        end
    end

    // p squared
    assign pp_full = r_m1.p * r_m1.p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2 <= '0;
        end else if (en) begin
            r_m2 <= r_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m2_q  <= r_m1_q;
            r_m2_pp <= pp_full[2*DATA_WIDTH-1:FRAC_BITS];
        end
    end

    // discriminant, its sign and the radicand
    assign dis     = $signed({2'b00, r_m2_pp}) - DIS_W'(r_m2_q);
    assign neg_tol = -$signed({{(DIS_W-TOL_W){1'b0}}, r_tol});
    assign dis_mag = dis[DIS_W-1] ? DIS_W'(-dis) : DIS_W'(dis);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3 <= '0;
        end else if (en) begin
            r_m3 <= '{v: r_m2.v, quad: r_m2.quad, err: r_m2.err,
                      real_roots: dis >= neg_tol, dneg: dis[DIS_W-1],
                      p: r_m2.p, lin: r_m2.lin};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m3_rad <= {dis_mag[RAD_W-FRAC_BITS-1:0], FRAC_BITS'(0)};
        end
    end

    qrs_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_m3_rad),
        .o_root (sq_root)
    );

    // side data along the square root
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < ROOT_W; k++) begin
                r_sside[k] <= '0;
            end
        end else if (en) begin
            r_sside[0] <= r_m3;
            for (int k = 1; k < ROOT_W; k++) begin
                r_sside[k] <= r_sside[k-1];
            end
        end
    end

    // root assembly
    assign fin    = r_sside[ROOT_W-1];
    assign neg_p  = -SUM_W'(fin.p);
    assign s_full = $signed({2'b00, sq_root});
    assign s_eff  = fin.dneg ? '0 : s_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= fin.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (fin.quad) begin
                o_root_count   <= CNT_QUAD;
                o_divide_error <= 1'b0;
                if (fin.real_roots) begin
                    o_root_a_real <= sat_sum(neg_p + s_eff);
                    o_root_a_imag <= '0;
                    o_root_b_real <= sat_sum(neg_p - s_eff);
                    o_root_b_imag <= '0;
                end else begin
                    o_root_a_real <= sat_sum(neg_p);
                    o_root_a_imag <= sat_sum(s_full);
                    o_root_b_real <= sat_sum(neg_p);
                    o_root_b_imag <= sat_sum(-s_full);
                end
            end else if (!fin.err) begin
                o_root_count   <= CNT_LINEAR;
                o_divide_error <= 1'b0;
                o_root_a_real  <= fin.lin;
                o_root_a_imag  <= '0;
                o_root_b_real  <= '0;
                o_root_b_imag  <= '0;
            end else begin
                o_root_count   <= CNT_NONE;
                o_divide_error <= 1'b1;
                o_root_a_real  <= '0;
                o_root_a_imag  <= '0;
                o_root_b_real  <= '0;
                o_root_b_imag  <= '0;
            end
        end
    end

    assign o_valid = r_out_v;

    // an empty input register always takes a beat
    a_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_v |-> o_ready)
        else $error("input register empty but not ready");

    // error results carry no roots
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divide_error |->
            o_root_count == CNT_NONE && o_root_a_real == '0 && o_root_b_real == '0)
        else $error("divide error with nonzero roots");

    // a linear result has no second root
    a_lin_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_root_count == CNT_LINEAR |->
            o_root_b_real == '0 && o_root_b_imag == '0 && o_root_a_imag == '0)
        else $error("linear result with second root");

    // a stalled output freezes the stage feeding it
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(r_sside[ROOT_W-1]))
        else $error("pipe moved during stall");

endmodule

FILE: bench/quadratic_root_solver_tb.sv
`timescale 1ns / 1ps

module quadratic_root_solver_tb;
    import qrs_pkg::*;

    localparam int LATENCY     = 85;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 1300;

    typedef logic signed [DATA_WIDTH-1:0] t_word;

    typedef struct {
        t_word c0;
        t_word c1;
        t_word c2;
    } t_equation;

    typedef struct {
        t_word      a_re;
        t_word      a_im;
        t_word      b_re;
        t_word      b_im;
        logic [1:0] count;
        logic       err;
    } t_roots;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [TOL_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    t_word i_coef_c0 = '0;
    t_word i_coef_c1 = '0;
    t_word i_coef_c2 = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    t_word o_root_a_real, o_root_a_imag, o_root_b_real, o_root_b_imag;
    logic [1:0] o_root_count;
    logic o_divide_error;

    t_equation pending_eqs[$];
    t_roots    expected_roots[$];
    logic [TOL_W-1:0] tol_shadow = TOL_RESET;
    int  error_count = 0;
    int  cycle_count = 0;
    bit  idle_off = 1'b0;
    bit  send_hold = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    bit  in_reset = 1'b1;

    quadratic_root_solver u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_coef_c0(i_coef_c0), .i_coef_c1(i_coef_c1), .i_coef_c2(i_coef_c2),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_root_a_real(o_root_a_real), .o_root_a_imag(o_root_a_imag),
        .o_root_b_real(o_root_b_real), .o_root_b_imag(o_root_b_imag),
        .o_root_count(o_root_count), .o_divide_error(o_divide_error)
    );

    always #5 i_clk = ~i_clk;

    // integer square root, floor
    function automatic longint unsigned floor_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_word clamp_word(input longint v);
        longint hi;
        longint lo;
        hi = longint'(DATA_MAX);
        lo = longint'(DATA_MIN);
        if (v > hi) return DATA_MAX;
        if (v < lo) return DATA_MIN;
        return t_word'(v);
    endfunction

    // expected roots for one equation under the current tolerance
    function automatic t_roots solve_equation(input t_equation e);
        t_roots r;
        longint one, c0, c1, c2, tol, mag2, p, q, pp, d, s;
        one = longint'(1) << FRAC_BITS;
        c0 = e.c0;
        c1 = e.c1;
        c2 = e.c2;
        tol = longint'(tol_shadow);
        mag2 = c2 < 0 ? -c2 : c2;
        r = '{default: '0};
        if (mag2 > tol) begin
            p = clamp_word((c1 * one) / (2 * c2));
            q = clamp_word((c0 * one) / c2);
            pp = longint'(longint'(unsigned'(p * p)) >> FRAC_BITS);
            d = pp - q;
            if (d >= -tol) begin
                s = d > 0 ? longint'(floor_sqrt(longint'(d) << FRAC_BITS)) : 0;
                r.a_re = clamp_word(-p + s);
                r.b_re = clamp_word(-p - s);
            end else begin
                s = longint'(floor_sqrt(longint'(-d) << FRAC_BITS));
                r.a_re = clamp_word(-p);
                r.a_im = clamp_word(s);
                r.b_re = clamp_word(-p);
                r.b_im = clamp_word(-s);
            end
            r.count = CNT_QUAD;
        end else if (c1 != 0) begin
            r.a_re = clamp_word(-((c0 * one) / c1));
            r.count = CNT_LINEAR;
        end else begin
            r.count = CNT_NONE;
            r.err = 1'b1;
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // driver: one beat per handshake, random gaps
    always @(posedge i_clk) begin
        t_equation e;
        if (!in_reset) begin
            if (i_valid && o_ready) begin
                expected_roots.push_back(solve_equation(
                    '{i_coef_c0, i_coef_c1, i_coef_c2}));
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_eqs.size() > 0 && !send_hold) begin
                    e = pending_eqs.pop_front();
                    i_valid <= 1'b1;
                    i_coef_c0 <= e.c0;
                    i_coef_c1 <= e.c1;
                    i_coef_c2 <= e.c2;
                    if (!idle_off && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 15);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_roots w;
        if (!in_reset) begin
            if (o_valid && i_ready) begin
                if (expected_roots.size() == 0) begin
                    report_mismatch("unexpected beat", 0, 0);
                end else begin
                    w = expected_roots.pop_front();
                    if (o_root_a_real !== w.a_re) report_mismatch("a_real", o_root_a_real, w.a_re);
                    if (o_root_a_imag !== w.a_im) report_mismatch("a_imag", o_root_a_imag, w.a_im);
                    if (o_root_b_real !== w.b_re) report_mismatch("b_real", o_root_b_real, w.b_re);
                    if (o_root_b_imag !== w.b_im) report_mismatch("b_imag", o_root_b_imag, w.b_im);
                    if (o_root_count !== w.count) report_mismatch("count", o_root_count, w.count);
                    if (o_divide_error !== w.err) report_mismatch("error", o_divide_error, w.err);
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                i_ready <= 1'b0;
            end else if (!idle_off && $urandom_range(0, 11) == 0) begin
                recv_gap <= $urandom_range(0, 14);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic t_word rand_coef();
        case ($urandom_range(0, 5))
            0: return t_word'($urandom);
            1: return t_word'($signed($urandom_range(0, 20)) - 10);
            2: return t_word'(($signed($urandom_range(0, 16)) - 8) <<< FRAC_BITS);
            3: return t_word'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            4: return $urandom_range(0, 1) ? DATA_MAX : DATA_MIN;
            default: return t_word'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
        endcase
    endfunction

    // wait for the pipe to drain
    task automatic drain();
        while (pending_eqs.size() > 0 || i_valid || expected_roots.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        tol_shadow = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic queue_random(input int n);
        t_equation e;
        repeat (n) begin
            e.c0 = rand_coef();
            e.c1 = rand_coef();
            e.c2 = rand_coef();
            if ($urandom_range(0, 7) == 0) e.c2 = t_word'($urandom_range(0, 2 * tol_shadow + 2))
                                              - t_word'(tol_shadow + 1);
            if ($urandom_range(0, 15) == 0) e.c1 = '0;
            pending_eqs.push_back(e);
        end
    endtask

    initial begin
        t_word one;
        one = t_word'(1) <<< FRAC_BITS;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        in_reset = 1'b0;

        // directed: real, complex, linear, both zero, extremes, tolerance edges
        pending_eqs.push_back('{-4 * one, '0, one});
        pending_eqs.push_back('{2 * one, -3 * one, one});
        pending_eqs.push_back('{4 * one, '0, one});
        pending_eqs.push_back('{one, 2 * one, one});
        pending_eqs.push_back('{one, 2 * one, '0});
        pending_eqs.push_back('{one, 2 * one, t_word'(1)});
        pending_eqs.push_back('{one, 2 * one, t_word'(-1)});
        pending_eqs.push_back('{one, 2 * one, t_word'(2)});
        pending_eqs.push_back('{one, '0, '0});
        pending_eqs.push_back('{one, '0, t_word'(-1)});
        pending_eqs.push_back('{DATA_MAX, DATA_MAX, DATA_MAX});
        pending_eqs.push_back('{DATA_MIN, DATA_MIN, DATA_MIN});
        pending_eqs.push_back('{DATA_MAX, DATA_MIN, t_word'(2)});
        pending_eqs.push_back('{DATA_MIN, DATA_MAX, t_word'(-2)});
        pending_eqs.push_back('{DATA_MAX, t_word'(1), '0});
        pending_eqs.push_back('{DATA_MIN, t_word'(-1), '0});
        pending_eqs.push_back('{t_word'(1), t_word'(2), one});
        pending_eqs.push_back('{'1, '1, '1});
        drain();

        // tolerance sweep: extremes and a middle value
        write_tolerance(16'hFFFF);
        pending_eqs.push_back('{one, 2 * one, t_word'(16'hFFFF)});
        pending_eqs.push_back('{one, 2 * one, t_word'(32'h10000)});
        pending_eqs.push_back('{t_word'(-5), '0, one});
        queue_random(250);
        drain();

        write_tolerance('0);
        pending_eqs.push_back('{one, one, t_word'(1)});
        pending_eqs.push_back('{one, one, '0});
        queue_random(250);
        // sender holds until all results are back
        while (pending_eqs.size() > 100) @(posedge i_clk);
        send_hold = 1'b1;
        while (i_valid || expected_roots.size() > 0) @(posedge i_clk);
        send_hold = 1'b0;
        drain();

        write_tolerance(16'd300);
        queue_random(400);
        drain();

        write_tolerance(TOL_RESET);
        queue_random(250);
        while (pending_eqs.size() > 0) @(posedge i_clk);
        idle_off = 1'b1;
        queue_random(150);
        drain();

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/qrs_pkg.sv
rtl/qrs_div.sv
rtl/qrs_isqrt.sv
rtl/quadratic_root_solver.sv
bench/quadratic_root_solver_tb.sv
